FILE: sv/qsi_pkg.sv
// ----------------------------------------------------------------------------
// qsi_pkg
// Shared types and constants for the quicksort-with-index unit.
// ----------------------------------------------------------------------------
`default_nettype none
package qsi_pkg;
  localparam int unsigned MaxItemsDef = 64;
  localparam int unsigned ValW = 32;
  localparam int unsigned PosW = 6;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               end_of_set;
  } qsi_in_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic [5:0]         source_position;
    logic               final_result;
    logic               overflowed;
  } qsi_out_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic [5:0]         pos;
  } qsi_entry_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_INIT, ST_POP, ST_PIV_RD, ST_PIV_WT, ST_PIV_GET,
    ST_I_RD, ST_I_WT, ST_I_CMP, ST_J_RD, ST_J_WT, ST_J_CMP,
    ST_SWAP_A, ST_SWAP_B, ST_NEXT, ST_PUSH_R, ST_PUSH_L,
    ST_OUT_RD, ST_OUT_WT, ST_OUT_EMIT
  } qsi_state_e;
endpackage
`default_nettype wire

FILE: sv/quicksort_with_index_unit.sv
// ----------------------------------------------------------------------------
// quicksort_with_index_unit
// Loads signed samples, sorts them with an iterative quicksort, emits them
// in increasing order with their arrival positions.
// ----------------------------------------------------------------------------
// Usage: drive in_i and pulse start_i while busy is low. A transaction with
// end_of_set set stores its sample (if room) and starts the sort; busy stays
// high until the burst is out. Values beyond MAX_ITEMS are dropped and
// flagged in overflowed. The sort runs on one entry store with one port:
// each element read passes through address, RAM wait and compare states,
// a swap writes the two entries back in turn, and a range pop or push has
// a state of its own. Results appear on out_o with out_valid_o high for
// one cycle each; the receiver cannot stall them. final_result marks the
// last one. Reset clears the fill count, overflow flag, range stack
// pointer and sequencer; the entry store is not cleared and needs no
// clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module quicksort_with_index_unit #(
  parameter int unsigned MAX_ITEMS = qsi_pkg::MaxItemsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire qsi_pkg::qsi_in_t in_i,
  output logic                  busy,
  output logic                  out_valid_o,
  output qsi_pkg::qsi_out_t     out_o
);
  import qsi_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned SD = MAX_ITEMS / 2;
  localparam int unsigned SAW = (SD > 1) ? $clog2(SD) : 1;

  qsi_state_e state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          ovf_q, ovf_d;
  logic [AW:0]   sp_q, sp_d;
  logic [AW-1:0] stk_lo_q [SD];
  logic [AW-1:0] stk_hi_q [SD];
  logic          push_en;
  logic [AW-1:0] push_lo, push_hi;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic signed [CW:0] i_q, i_d, j_q, j_d;
  logic signed [31:0] piv_q, piv_d;
  qsi_entry_t    ei_q, ei_d;
  logic [AW-1:0] k_q, k_d;

  logic          we;
  logic [AW-1:0] addr;
  qsi_entry_t    wdata, rdata;

  qsi_ram #(.Width(ValW + PosW), .Depth(MAX_ITEMS)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign busy = (state_q != ST_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      sp_q    <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      sp_q    <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    i_q   <= i_d;
    j_q   <= j_d;
    piv_q <= piv_d;
    ei_q  <= ei_d;
    k_q   <= k_d;
    if (push_en) begin
      stk_lo_q[sp_q[SAW-1:0]] <= push_lo;
      stk_hi_q[sp_q[SAW-1:0]] <= push_hi;
    end
  end

  logic [AW:0] mid;
  assign mid = ({1'b0, lo_q} + {1'b0, hi_q}) >> 1;

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    ovf_d   = ovf_q;
    sp_d    = sp_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    i_d     = i_q;
    j_d     = j_q;
    piv_d   = piv_q;
    ei_d    = ei_q;
    k_d     = k_q;
    push_en = 1'b0;
    push_lo = '0;
    push_hi = '0;
    we      = 1'b0;
    addr    = '0;
    wdata   = '0;
    out_valid_o = 1'b0;
    out_o   = '0;
    case (state_q)
      ST_LOAD: begin
        if (start_i) begin
          if (fill_q < CW'(MAX_ITEMS)) begin
            we     = 1'b1;
            addr   = fill_q[AW-1:0];
            wdata  = '{val: in_i.sample, pos: PosW'(fill_q)};
            fill_d = fill_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.end_of_set) begin
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        sp_d = '0;
        if (fill_q >= CW'(2)) begin
          push_en = 1'b1;
          push_lo = '0;
          push_hi = AW'(fill_q - 1'b1);
          sp_d    = (AW+1)'(1);
          state_d = ST_POP;
        end else begin
          k_d     = '0;
          state_d = ST_OUT_RD;
        end
      end
      ST_POP: begin
        if (sp_q == '0) begin
          k_d     = '0;
          state_d = ST_OUT_RD;
        end else begin
          sp_d    = sp_q - 1'b1;
          lo_d    = stk_lo_q[SAW'(sp_q - 1'b1)];
          hi_d    = stk_hi_q[SAW'(sp_q - 1'b1)];
          i_d     = (CW+1)'(stk_lo_q[SAW'(sp_q - 1'b1)]);
          j_d     = (CW+1)'(stk_hi_q[SAW'(sp_q - 1'b1)]);
          state_d = ST_PIV_RD;
        end
      end
      ST_PIV_RD: begin
        addr    = mid[AW-1:0];
        state_d = ST_PIV_WT;
      end
      ST_PIV_WT: begin
        addr    = mid[AW-1:0];
        state_d = ST_PIV_GET;
      end
      ST_PIV_GET: begin
        piv_d   = rdata.val;
        state_d = ST_I_RD;
      end
      ST_I_RD: begin
        addr    = i_q[AW-1:0];
        state_d = ST_I_WT;
      end
      ST_I_WT: begin
        addr    = i_q[AW-1:0];
        state_d = ST_I_CMP;
      end
      ST_I_CMP: begin
        addr = i_q[AW-1:0];
        if (rdata.val < piv_q && i_q < $signed((CW+1)'(hi_q))) begin
          i_d     = i_q + 1'b1;
          state_d = ST_I_RD;
        end else begin
          ei_d    = rdata;
          state_d = ST_J_RD;
        end
      end
      ST_J_RD: begin
        addr    = j_q[AW-1:0];
        state_d = ST_J_WT;
      end
      ST_J_WT: begin
        addr    = j_q[AW-1:0];
        state_d = ST_J_CMP;
      end
      ST_J_CMP: begin
        addr = j_q[AW-1:0];
        if (piv_q < rdata.val && j_q > $signed((CW+1)'(lo_q))) begin
          j_d     = j_q - 1'b1;
          state_d = ST_J_RD;
        end else if (i_q <= j_q) begin
          we      = 1'b1;
          wdata   = ei_q;
          ei_d    = rdata;
          state_d = ST_SWAP_A;
        end else begin
          state_d = ST_PUSH_R;
        end
      end
      ST_SWAP_A: begin
        we      = 1'b1;
        addr    = i_q[AW-1:0];
        wdata   = ei_q;
        i_d     = i_q + 1'b1;
        j_d     = j_q - 1'b1;
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        state_d = (i_q <= j_q) ? ST_I_RD : ST_PUSH_R;
      end
      ST_PUSH_R: begin
        if (i_q < $signed((CW+1)'(hi_q)) && sp_q < (AW+1)'(SD)) begin
          push_en = 1'b1;
          push_lo = i_q[AW-1:0];
          push_hi = hi_q;
          sp_d    = sp_q + 1'b1;
        end
        state_d = ST_PUSH_L;
      end
      ST_PUSH_L: begin
        if ($signed((CW+1)'(lo_q)) < j_q && sp_q < (AW+1)'(SD)) begin
          push_en = 1'b1;
          push_lo = lo_q;
          push_hi = j_q[AW-1:0];
          sp_d    = sp_q + 1'b1;
        end
        state_d = ST_POP;
      end
      ST_OUT_RD: begin
        addr = k_q;
        if (fill_q == '0) begin
          ovf_d   = 1'b0;
          state_d = ST_LOAD;
        end else begin
          state_d = ST_OUT_WT;
        end
      end
      ST_OUT_WT: begin
        addr    = k_q;
        state_d = ST_OUT_EMIT;
      end
      ST_OUT_EMIT: begin
        out_valid_o = 1'b1;
        out_o.sorted_value    = rdata.val;
        out_o.source_position = rdata.pos;
        out_o.final_result    = (CW'(k_q) == fill_q - 1'b1);
        out_o.overflowed      = ovf_q;
        if (CW'(k_q) == fill_q - 1'b1) begin
          fill_d  = '0;
          ovf_d   = 1'b0;
          sp_d    = '0;
          state_d = ST_LOAD;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_OUT_RD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end
endmodule
`default_nettype wire

FILE: sv/qsi_ram.sv
// ----------------------------------------------------------------------------
// qsi_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module qsi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

FILE: sv/qsi_checker.sv
// ----------------------------------------------------------------------------
// qsi_checker
// Port-level checks for the quicksort-with-index unit.
// ----------------------------------------------------------------------------
`default_nettype none
module qsi_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire qsi_pkg::qsi_in_t  in_i,
  input wire logic              busy,
  input wire logic              out_valid_o,
  input wire qsi_pkg::qsi_out_t out_o
);
  import qsi_pkg::*;

  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy) else $error("result while idle");
  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.final_result |=> !busy) else $error("busy after final");
  a_eos_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy && in_i.end_of_set |=> busy) else $error("sort not started");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy && !in_i.end_of_set |=> !busy && !out_valid_o)
    else $error("load made busy");
endmodule

bind quicksort_with_index_unit qsi_checker u_qsi_checker (.*);
`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for quicksort_with_index_unit: loads sets of signed
// samples, predicts the sorted burst with an iterative middle-pivot quicksort
// and checks every result field by field, under random sender idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class sort_scoreboard;
  qsi_pkg::qsi_out_t pending_results[$];
  logic signed [31:0] vals[64];
  logic [5:0]         tags[64];
  int                 fill;
  bit                 dropped;
  int                 errors;

  function new();
    fill = 0;
    dropped = 0;
    errors = 0;
  endfunction

  function void report(string msg);
    $display("ERROR %0t: %s", $time, msg);
    errors++;
  endfunction

  function void swap_pair(int a, int b);
    logic signed [31:0] tv;
    logic [5:0]         tp;
    tv = vals[a]; tp = tags[a];
    vals[a] = vals[b]; tags[a] = tags[b];
    vals[b] = tv; tags[b] = tp;
  endfunction

  function void quicksort_set();
    int lo_q[$];
    int hi_q[$];
    int lo, hi, i, j;
    logic signed [31:0] pivot;
    if (fill < 2) return;
    lo_q.push_back(0);
    hi_q.push_back(fill - 1);
    while (lo_q.size() > 0) begin
      lo = lo_q.pop_back();
      hi = hi_q.pop_back();
      i = lo;
      j = hi;
      pivot = vals[(lo + hi) / 2];
      do begin
        while (vals[i] < pivot && i < hi) i++;
        while (pivot < vals[j] && j > lo) j--;
        if (i <= j) begin
          swap_pair(i, j);
          i++;
          j--;
        end
      end while (i <= j);
      if (i < hi) begin
        lo_q.push_back(i);
        hi_q.push_back(hi);
      end
      if (lo < j) begin
        lo_q.push_back(lo);
        hi_q.push_back(j);
      end
    end
  endfunction

  function void note_input(qsi_pkg::qsi_in_t t);
    qsi_pkg::qsi_out_t r;
    if (fill < 64) begin
      vals[fill] = t.sample;
      tags[fill] = fill[5:0];
      fill++;
    end else begin
      dropped = 1;
    end
    if (!t.end_of_set) return;
    quicksort_set();
    for (int k = 0; k < fill; k++) begin
      r.sorted_value = vals[k];
      r.source_position = tags[k];
      r.final_result = (k == fill - 1);
      r.overflowed = dropped;
      pending_results.push_back(r);
    end
    fill = 0;
    dropped = 0;
  endfunction

  function void check_result(qsi_pkg::qsi_out_t got);
    qsi_pkg::qsi_out_t exp_r;
    if (pending_results.size() == 0) begin
      report($sformatf("unexpected result %h", got));
      return;
    end
    exp_r = pending_results.pop_front();
    if (got.sorted_value !== exp_r.sorted_value)
      report($sformatf("sorted_value %h, want %h", got.sorted_value, exp_r.sorted_value));
    if (got.source_position !== exp_r.source_position)
      report($sformatf("source_position %0d, want %0d", got.source_position,
                       exp_r.source_position));
    if (got.final_result !== exp_r.final_result)
      report($sformatf("final_result %b, want %b", got.final_result, exp_r.final_result));
    if (got.overflowed !== exp_r.overflowed)
      report($sformatf("overflowed %b, want %b", got.overflowed, exp_r.overflowed));
  endfunction
endclass

module tb_top;
  import qsi_pkg::*;

  localparam int WatchdogLimit = 200000;

  logic     clk_i = 0;
  logic     rst_ni = 0;
  logic     start_i = 0;
  qsi_in_t  in_i = '0;
  logic     busy;
  logic     out_valid_o;
  qsi_out_t out_o;

  sort_scoreboard board = new();
  int idle_pct = 0;
  int sent = 0;
  int stall_cycles = 0;

  quicksort_with_index_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .in_i(in_i),
    .busy(busy), .out_valid_o(out_valid_o), .out_o(out_o)
  );

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy) board.note_input(in_i);
      if (out_valid_o) board.check_result(out_o);
      if ((start_i && !busy) || out_valid_o) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > WatchdogLimit) begin
        $display("FAIL quicksort_with_index_unit");
        $finish;
      end
    end
  end

  function automatic logic signed [31:0] pick_sample(int mode);
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 3) - 1;
      default: return mode ? $urandom_range(0, 5) : $urandom();
    endcase
  endfunction

  task automatic send_one(logic signed [31:0] s, logic eos);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 0;
      @(posedge clk_i);
    end
    start_i <= 1;
    in_i <= '{sample: s, end_of_set: eos};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_set(int n, int mode);
    for (int k = 0; k < n; k++) send_one(pick_sample(mode), k == n - 1);
  endtask

  task automatic drain();
    start_i <= 0;
    @(posedge clk_i);
    while (board.pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_one(32'sh7fffffff, 1);
    send_one(32'sh80000000, 0);
    send_one(32'sh7fffffff, 1);
    send_one(5, 0); send_one(5, 0); send_one(-3, 0); send_one(5, 0);
    send_one(32'sh80000000, 0); send_one(0, 1);
    for (int k = 0; k < 66; k++) send_one($urandom(), k == 65);
    drain();
    repeat (20) @(posedge clk_i);
    while (sent < 460) begin
      case ((sent / 60) % 4)
        0: idle_pct = 0;
        1, 2: idle_pct = 59;
        default: idle_pct = 28;
      endcase
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
      send_set(n, $urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) drain();
    end
    drain();
    repeat (50) @(posedge clk_i);
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("PASS quicksort_with_index_unit");
    end else begin
      $display("FAIL quicksort_with_index_unit");
    end
    $finish;
  end
endmodule

FILE: files.f
sv/qsi_pkg.sv
sv/qsi_ram.sv
sv/quicksort_with_index_unit.sv
sv/qsi_checker.sv
test/tb_top.sv
